// ----- rtl/sict_pkg.sv -----
// shared types, codes and constants for the subarray inversion count table
`default_nettype none

package sict_pkg;

   localparam int MAX_N_DEFAULT = 128;

   localparam int CNT_W = 13;
   localparam logic [CNT_W-1:0] CNT_MAX = 13'h1fff;

   localparam int LEN_W = 8;
   localparam logic [LEN_W-1:0] LEN_RESET = 8'd128;

   // request codes
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_BUILD = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_BUILT     = 2'd1;
   localparam logic [1:0] STAT_RANGE     = 2'd2;
   localparam logic [1:0] STAT_NOT_BUILT = 2'd3;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [6:0]         position;
      logic signed [31:0] value;
      logic [6:0]         left;
      logic [6:0]         right;
   } req_item_type;

   typedef struct packed {
      logic [CNT_W-1:0] inversion_count;
      logic [1:0]       status;
   } rsp_item_type;

   typedef struct packed {
      logic busy;
      logic done;
   } build_stat_type;

endpackage

`default_nettype wire

// ----- rtl/sict_ram.sv -----
// generic single write port, single read port ram with registered read
`default_nettype none

module sict_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/sict_build.sv -----
// table build sequencer: one shared compare and saturating accumulate unit
`default_nettype none

module sict_build
   import sict_pkg::*;
#(
   parameter int MAX_N = MAX_N_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [$clog2(MAX_N+1)-1:0]        n,
   output logic      [$clog2(MAX_N)-1:0]          elem_raddr,
   input  wire logic [31:0]                       elem_rdata,
   output logic                                   tbl_we,
   output logic      [2*$clog2(MAX_N)-1:0]        tbl_waddr,
   output logic      [CNT_W-1:0]                  tbl_wdata,
   output build_stat_type                         stat
);

   localparam int AW = $clog2(MAX_N);
   localparam int CW = $clog2(MAX_N + 1);
   localparam int GW = $clog2(MAX_N);

   typedef enum logic [2:0] {
      B_IDLE,
      B_ROW_RD,
      B_ROW_LD,
      B_COL_RD,
      B_COL_UPD,
      B_DONE
   } bstate_type;

   bstate_type         state_ff, state_in;
   logic [AW-1:0]      i_ff, i_in;
   logic [CW-1:0]      j_ff, j_in;
   logic [CW-1:0]      n_ff, n_in;
   logic signed [31:0] vi_ff, vi_in;
   logic [CNT_W-1:0]   run_ff, run_in;

   logic [GW-1:0]      gc_rdata;
   logic [GW-1:0]      gc_old;
   logic [GW-1:0]      gc_new;
   logic               gc_we;
   logic               gt;
   logic [CNT_W:0]     sum;
   logic [CNT_W-1:0]   sat;
   logic [CW-1:0]      j_nxt;
   logic [CW-1:0]      j_first;

   sict_ram #(
      .WIDTH (GW),
      .DEPTH (MAX_N)
   ) u_gc_ram (
      .clock (clock),
      .we    (gc_we),
      .waddr (j_ff[AW-1:0]),
      .wdata (gc_new),
      .raddr (j_ff[AW-1:0]),
      .rdata (gc_rdata)
   );

   assign j_nxt   = j_ff + CW'(1);
   assign j_first = CW'(i_ff) + CW'(1);

   // first touch of column j happens on row j-1, so the count starts at zero there
   assign gt     = vi_ff > $signed(elem_rdata);
   assign gc_old = (j_ff == j_first) ? '0 : gc_rdata;
   assign gc_new = gc_old + GW'(gt);
   assign sum    = {1'b0, run_ff} + (CNT_W+1)'(gc_new);
   assign sat    = (sum > (CNT_W+1)'(CNT_MAX)) ? CNT_MAX : sum[CNT_W-1:0];

   assign gc_we     = (state_ff == B_COL_UPD);
   assign tbl_we    = (state_ff == B_COL_UPD);
   assign tbl_waddr = {i_ff, j_ff[AW-1:0]};
   assign tbl_wdata = sat;

   always_comb begin
      elem_raddr = i_ff;
      if (state_ff == B_COL_RD) begin
         elem_raddr = j_ff[AW-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      n_in     = n_ff;
      vi_in    = vi_ff;
      run_in   = run_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (start) begin
               n_in = n;
               i_in = AW'(n - CW'(1));
               if (n == '0) begin
                  state_in = B_DONE;
               end else begin
                  state_in = B_ROW_RD;
               end
            end
         end
         B_ROW_RD: begin
            state_in = B_ROW_LD;
         end
         B_ROW_LD: begin
            vi_in  = $signed(elem_rdata);
            run_in = '0;
            j_in   = j_first;
            if (j_first >= n_ff) begin
               // row holds no pairs
               if (i_ff == '0) begin
                  state_in = B_DONE;
               end else begin
                  i_in     = i_ff - AW'(1);
                  state_in = B_ROW_RD;
               end
            end else begin
               state_in = B_COL_RD;
            end
         end
         B_COL_RD: begin
            state_in = B_COL_UPD;
         end
         B_COL_UPD: begin
            run_in = sat;
            j_in   = j_nxt;
            if (j_nxt >= n_ff) begin
               if (i_ff == '0) begin
                  state_in = B_DONE;
               end else begin
                  i_in     = i_ff - AW'(1);
                  state_in = B_ROW_RD;
               end
            end else begin
               state_in = B_COL_RD;
            end
         end
         B_DONE: begin
            state_in = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff   <= i_in;
      j_ff   <= j_in;
      n_ff   <= n_in;
      vi_ff  <= vi_in;
      run_ff <= run_in;
   end

   assign stat.busy = (state_ff != B_IDLE);
   assign stat.done = (state_ff == B_DONE);

endmodule

`default_nettype wire

// ----- rtl/subarray_inversion_count_table.sv -----
// subarray inversion count table: request decode, element and count stores
//
// Requests arrive on req_ (valid/stall) as one item each: write element,
// build table or query range. Results leave on rsp_ (valid/stall) as one
// item with a count and a status. csr_ (valid/ready) writes array_length.
//
// A write gives no result; writes may follow back to back. A query result
// is registered after at most one count-store read. A build walks the
// triangular table for n = min(array_length, MAX_N) with one shared
// compare and accumulate unit, reading each column's element and partial
// count, then writing back both counts, entry by entry; req_stall stays high
// throughout. A pending result is held in the output register while
// rsp_stall is high; a new request is still taken, but a further result
// waits until the output register frees up. Reset is synchronous: it clears
// the table-built flag, sets array_length to 128 and drops rsp_valid. The
// element and count stores are not cleared and need no clearing pass.
`default_nettype none

module subarray_inversion_count_table
   import sict_pkg::*;
#(
   parameter int MAX_N = MAX_N_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_item_type       req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_item_type            rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [LEN_W-1:0]   csr_data
);

   localparam int AW = $clog2(MAX_N);
   localparam int CW = $clog2(MAX_N + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_BUILD,
      S_QRD,
      S_RESP
   } state_type;

   state_type        state_ff, state_in;
   logic             built_ff, built_in;
   logic [CW-1:0]    built_n_ff, built_n_in;
   logic [LEN_W-1:0] len_ff, len_in;
   rsp_item_type     res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_data_ff, rsp_data_in;

   logic             accept;
   logic [CW-1:0]    used_n;
   logic             q_oob;
   logic             q_zero;
   logic             elem_we;
   logic             build_start;
   logic [AW-1:0]    elem_raddr;
   logic [31:0]      elem_rdata;
   logic             tbl_we;
   logic [2*AW-1:0]  tbl_waddr;
   logic [CNT_W-1:0] tbl_wdata;
   logic [CNT_W-1:0] tbl_rdata;
   build_stat_type   bstat;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (32'(len_ff) >= 32'(MAX_N)) begin
         used_n = CW'(MAX_N);
      end else begin
         used_n = CW'(len_ff);
      end
   end

   assign q_oob = (32'(req_data.left) >= 32'(used_n)) || (32'(req_data.right) >= 32'(used_n));
   // empty or single-element ranges, and ranges beyond the last build, count zero
   assign q_zero = (req_data.left >= req_data.right)
                || (32'(req_data.right) >= 32'(built_n_ff));

   assign elem_we     = accept && (req_data.req_type == REQ_WRITE)
                     && (32'(req_data.position) < 32'(MAX_N));
   assign build_start = accept && (req_data.req_type == REQ_BUILD);

   sict_ram #(
      .WIDTH (32),
      .DEPTH (MAX_N)
   ) u_elem_ram (
      .clock (clock),
      .we    (elem_we),
      .waddr (AW'(req_data.position)),
      .wdata (req_data.value),
      .raddr (elem_raddr),
      .rdata (elem_rdata)
   );

   sict_ram #(
      .WIDTH (CNT_W),
      .DEPTH (1 << (2 * AW))
   ) u_tbl_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .raddr ({AW'(req_data.left), AW'(req_data.right)}),
      .rdata (tbl_rdata)
   );

   sict_build #(
      .MAX_N (MAX_N)
   ) u_build (
      .clock      (clock),
      .reset      (reset),
      .start      (build_start),
      .n          (used_n),
      .elem_raddr (elem_raddr),
      .elem_rdata (elem_rdata),
      .tbl_we     (tbl_we),
      .tbl_waddr  (tbl_waddr),
      .tbl_wdata  (tbl_wdata),
      .stat       (bstat)
   );

   always_comb begin
      state_in     = state_ff;
      built_in     = built_ff;
      built_n_in   = built_n_ff;
      len_in       = len_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         len_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  REQ_BUILD: begin
                     built_n_in = used_n;
                     state_in   = S_BUILD;
                  end
                  REQ_QUERY: begin
                     res_in.inversion_count = '0;
                     if (!built_ff) begin
                        res_in.status = STAT_NOT_BUILT;
                        state_in      = S_RESP;
                     end else if (q_oob) begin
                        res_in.status = STAT_RANGE;
                        state_in      = S_RESP;
                     end else if (q_zero) begin
                        res_in.status = STAT_OK;
                        state_in      = S_RESP;
                     end else begin
                        res_in.status = STAT_OK;
                        state_in      = S_QRD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_BUILD: begin
            if (bstat.done) begin
               built_in               = 1'b1;
               res_in.inversion_count = '0;
               res_in.status          = STAT_BUILT;
               state_in               = S_RESP;
            end
         end
         S_QRD: begin
            res_in.inversion_count = tbl_rdata;
            state_in               = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         built_ff     <= 1'b0;
         len_ff       <= LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         built_ff     <= built_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      built_n_ff  <= built_n_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/sict_checker.sv -----
// port-level checks for the subarray inversion count table, bound to the top level
`default_nettype none

module sict_checker
   import sict_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire req_item_type req_data,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_item_type rsp_data,
   input wire logic         csr_ready
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // build and query keep the block busy for at least the next cycle
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall
      && (req_data.req_type == REQ_BUILD || req_data.req_type == REQ_QUERY)
      |=> req_stall)
      else $error("request port reopened too early");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready == !req_stall)
      else $error("register port open while busy");

endmodule

bind subarray_inversion_count_table sict_checker u_sict_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);

`default_nettype wire

// ----- test/subarray_inversion_count_table_tb.sv -----
// testbench for the subarray inversion count table: random requests checked against a predictor
`timescale 1ns / 1ps

module subarray_inversion_count_table_tb;
   import sict_pkg::*;

   localparam int MAX_N = MAX_N_DEFAULT;
   localparam logic [1:0] REQ_NONE = 2'd3;
   localparam int QUIET_LIMIT = 100000;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int SETTLE_CYCLES = 8;

   logic           clock = 1'b0;
   logic           reset;
   logic           req_valid;
   logic           req_stall;
   req_item_type   req_data;
   logic           rsp_valid;
   logic           rsp_stall;
   rsp_item_type   rsp_data;
   logic           csr_valid;
   logic           csr_ready;
   logic [LEN_W-1:0] csr_data;

   subarray_inversion_count_table #(.MAX_N(MAX_N)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   class inversion_count_checker;
      logic signed [31:0] elem [MAX_N];
      logic [CNT_W-1:0]   inv_tab [MAX_N][MAX_N];
      bit                 built;
      logic [LEN_W-1:0]   length_reg;
      rsp_item_type       pending_counts [$];
      int                 mismatches;

      function new();
         built = 1'b0;
         length_reg = LEN_RESET;
         mismatches = 0;
      endfunction

      function int used_len();
         return (length_reg < MAX_N) ? int'(length_reg) : MAX_N;
      endfunction

      function void set_length(logic [LEN_W-1:0] v);
         length_reg = v;
      endfunction

      function int pending();
         return pending_counts.size();
      endfunction

      // count[i][j] = count[i][j-1] + elements in i..j-1 greater than element j
      function void build_counts();
         int n;
         int i;
         int j;
         int k;
         int run;
         int greater;
         n = used_len();
         for (i = 0; i < MAX_N; i++)
            for (j = 0; j < MAX_N; j++)
               inv_tab[i][j] = '0;
         for (i = 0; i < n; i++) begin
            run = 0;
            for (j = i + 1; j < n; j++) begin
               greater = 0;
               for (k = i; k < j; k++)
                  if (elem[k] > elem[j]) greater++;
               run += greater;
               if (run > CNT_MAX) run = CNT_MAX;
               inv_tab[i][j] = run[CNT_W-1:0];
            end
         end
         built = 1'b1;
      endfunction

      function void note_request(req_item_type r);
         rsp_item_type x;
         int n;
         n = used_len();
         x.inversion_count = '0;
         x.status = STAT_OK;
         case (r.req_type)
            REQ_WRITE: elem[r.position] = r.value;
            REQ_BUILD: begin
               build_counts();
               x.status = STAT_BUILT;
               pending_counts.push_back(x);
            end
            REQ_QUERY: begin
               // range check wins even for an empty range
               if (!built) begin
                  x.status = STAT_NOT_BUILT;
               end else if (r.left >= n || r.right >= n) begin
                  x.status = STAT_RANGE;
               end else if (r.left <= r.right) begin
                  x.inversion_count = inv_tab[r.left][r.right];
               end
               pending_counts.push_back(x);
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(rsp_item_type got);
         rsp_item_type want;
         if (pending_counts.size() == 0) begin
            report_mismatch($sformatf("unexpected item, count %0d status %0d",
                                      got.inversion_count, got.status));
            return;
         end
         want = pending_counts.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.inversion_count !== want.inversion_count)
            report_mismatch($sformatf("count %0d, expected %0d",
                                      got.inversion_count, want.inversion_count));
      endtask
   endclass

   inversion_count_checker sb;
   bit written_pos [MAX_N];
   bit burst_mode;
   bit long_hold;
   int quiet_cycles;

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || long_hold) return 0;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   function req_item_type junk_item();
      req_item_type r;
      r.req_type = 2'($urandom_range(0, 3));
      r.position = 7'($urandom_range(0, 127));
      r.value    = $urandom;
      r.left     = 7'($urandom_range(0, 127));
      r.right    = 7'($urandom_range(0, 127));
      return r;
   endfunction

   function logic signed [31:0] rand_value();
      case ($urandom_range(0, 5))
         0, 1, 2: return int'($urandom_range(0, 6)) - 3;
         3: return 32'sh7fff_ffff;
         4: return 32'sh8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function int rand_position();
      int n;
      n = sb.used_len();
      if (n > 0 && $urandom_range(0, 4) != 0) return $urandom_range(0, n - 1);
      return $urandom_range(0, 127);
   endfunction

   task send_item(input req_item_type r);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   task write_element(input int pos, input logic signed [31:0] v);
      req_item_type r;
      r = junk_item();
      r.req_type = REQ_WRITE;
      r.position = pos[6:0];
      r.value = v;
      written_pos[pos] = 1'b1;
      send_item(r);
   endtask

   // every element the build reads has to be written first
   task request_build();
      req_item_type r;
      int p;
      for (p = 0; p < sb.used_len(); p++)
         if (!written_pos[p]) write_element(p, rand_value());
      r = junk_item();
      r.req_type = REQ_BUILD;
      send_item(r);
   endtask

   task query_range(input int lo, input int hi);
      req_item_type r;
      r = junk_item();
      r.req_type = REQ_QUERY;
      r.left = lo[6:0];
      r.right = hi[6:0];
      send_item(r);
   endtask

   task send_ignored();
      req_item_type r;
      r = junk_item();
      r.req_type = REQ_NONE;
      send_item(r);
   endtask

   task random_query();
      int n;
      int lo;
      int hi;
      int t;
      n = sb.used_len();
      if (n > 0 && $urandom_range(0, 3) != 0) begin
         lo = $urandom_range(0, n - 1);
         hi = $urandom_range(0, n - 1);
         if (lo > hi && $urandom_range(0, 3) != 0) begin
            t = lo;
            lo = hi;
            hi = t;
         end
      end else begin
         lo = $urandom_range(0, 127);
         hi = $urandom_range(0, 127);
      end
      query_range(lo, hi);
   endtask

   task wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task write_length(input logic [LEN_W-1:0] v);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = v;
      do @(posedge clock); while (!csr_ready);
      sb.set_length(v);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_data = LEN_W'($urandom);
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         int r;
         r = $urandom_range(0, 99);
         if (long_hold) begin
            rsp_stall = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end else if (r < 45) begin
            rsp_stall = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end else if (r < 80) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end else if (r < 93) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(4, 15)) @(negedge clock);
         end else if (r < 97) begin
            rsp_stall = 1'b0;
            repeat ($urandom_range(40, 120)) @(negedge clock);
         end else begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(30, 60)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      int lengths [10];
      int ph;
      int i;
      int r;
      int n_items;
      sb = new();
      lengths = '{1, 128, 0, 255, 2, -1, 129, -1, 128, -1};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      burst_mode = 1'b0;
      long_hold = 1'b0;
      quiet_cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // nothing built yet, length still at its reset value
      query_range(0, 127);
      query_range(127, 0);
      send_ignored();
      write_length(4);

      write_element(0, 32'sh7fff_ffff);
      write_element(1, 32'sh8000_0000);
      write_element(2, 0);
      write_element(3, -1);
      write_element(127, 32'sh5555_aaaa);
      request_build();
      query_range(0, 3);
      query_range(3, 0);
      query_range(0, 4);
      query_range(4, 0);
      query_range(127, 127);
      query_range(1, 1);
      query_range(1, 3);
      // a write leaves the old table in place until the next build
      write_element(2, -1);
      query_range(0, 3);
      request_build();
      query_range(0, 3);
      query_range(2, 3);
      send_ignored();

      for (ph = 0; ph < 10; ph++) begin
         write_length(LEN_W'(lengths[ph] < 0 ? $urandom_range(3, 40) : lengths[ph]));
         burst_mode = (ph % 3 == 2);
         repeat ($urandom_range(2, 8)) write_element(rand_position(), rand_value());
         request_build();
         n_items = $urandom_range(20, 30);
         for (i = 0; i < n_items; i++) begin
            if (i == 10 && ph % 4 == 1) long_hold = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 30) begin
               write_element(rand_position(), rand_value());
            end else if (r < 85) begin
               random_query();
            end else if (r < 88) begin
               send_ignored();
            end else if (r < 92 && sb.used_len() <= 32) begin
               request_build();
            end else if (r < 94) begin
               wait_drained();
            end else begin
               random_query();
            end
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
